// File: rtl/core/hdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_pkg
// shared types and constants of the downhill deposit block
// ----------------------------------------------------------------------------
package hdd_pkg;

    typedef logic signed [15:0] height_t;

    localparam height_t HEIGHT_RESET = -16'sd650;
    localparam height_t HEIGHT_MAX   = 16'sd32767;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_THR  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_INC = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXHAUST_INC = 4'd3;

    localparam int CFG_DATA_W = 10;

    // register reset values
    localparam logic [7:0] MAX_STEPS_RESET   = 8'd40;
    localparam logic [9:0] SLOPE_THR_RESET   = 10'd20;
    localparam logic [9:0] SETTLE_INC_RESET  = 10'd10;
    localparam logic [9:0] EXHAUST_INC_RESET = 10'd100;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_drop;
        logic cap_here;
        logic rd_nb;
        logic nb_clr;
        logic nb_next;
        logic move;
        logic update;
    } hdd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic budget_done;
        logic nb_on_grid;
        logic nb_lower;
        logic nb_last;
    } hdd_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/hdd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module hdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: rtl/core/hdd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_ctrl
// sequencer for clearing, the downhill walk and the final update
// ----------------------------------------------------------------------------
module hdd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire hdd_pkg::hdd_sts_t sts,
    output hdd_pkg::hdd_cmd_t      cmd
);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_RD_HERE = 3'd2;
    localparam logic [2:0] S_HERE_W  = 3'd3;
    localparam logic [2:0] S_CHECK   = 3'd4;
    localparam logic [2:0] S_NB_SEL  = 3'd5;
    localparam logic [2:0] S_NB_W    = 3'd6;
    localparam logic [2:0] S_UPDATE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_drop = 1'b1;
                    state_next    = S_RD_HERE;
                end
            end
            S_RD_HERE:
            begin
                state_next = S_HERE_W;
            end
            S_HERE_W:
            begin
                cmd.cap_here = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.budget_done)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.nb_clr = 1'b1;
                    state_next = S_NB_SEL;
                end
            end
            S_NB_SEL:
            begin
                if (sts.nb_on_grid)
                begin
                    cmd.rd_nb  = 1'b1;
                    state_next = S_NB_W;
                end
                else if (sts.nb_last)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.nb_next = 1'b1;
                end
            end
            S_NB_W:
            begin
                if (sts.nb_lower)
                begin
                    cmd.move   = 1'b1;
                    state_next = S_CHECK;
                end
                else if (sts.nb_last)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.nb_next = 1'b1;
                    state_next  = S_NB_SEL;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // clearing happens once, after reset only
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clear pass re-entered");

    // a move needs a qualifying neighbour that was read from the grid
    a_move_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |-> ($past(cmd.rd_nb) && sts.nb_lower))
        else $error("move without a qualifying neighbour read");

endmodule
`default_nettype wire

// File: rtl/core/hdd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdd_datapath
// height map, walk position, neighbour test, saturating update and
// configuration registers
// ----------------------------------------------------------------------------
module hdd_datapath #(
    parameter int GRID = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire hdd_pkg::hdd_cmd_t                cmd,
    output hdd_pkg::hdd_sts_t                     sts,
    input  wire logic [5:0]                       drop_row,
    input  wire logic [5:0]                       drop_col,
    input  wire logic                             cfg_we,
    input  wire logic [hdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hdd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                  done,
    output logic [5:0]                            rest_row,
    output logic [5:0]                            rest_col,
    output hdd_pkg::height_t                      new_height,
    output logic [7:0]                            steps_taken,
    output logic                                  budget_exhausted
);

    localparam int CW    = $clog2(GRID);
    localparam int DEPTH = GRID * GRID;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [CW-1:0] LAST     = CW'(GRID - 1);
    localparam logic [8:0]    LAST9    = 9'(GRID - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0] GRID_A   = AW'(GRID);

    localparam logic [1:0] NB_ROW_UP   = 2'd0;
    localparam logic [1:0] NB_ROW_DOWN = 2'd1;
    localparam logic [1:0] NB_COL_UP   = 2'd2;
    localparam logic [1:0] NB_COL_DOWN = 2'd3;

    // configuration
    logic [7:0] max_steps_reg;
    logic [9:0] slope_thr_reg;
    logic [9:0] settle_inc_reg;
    logic [9:0] exhaust_inc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg   <= hdd_pkg::MAX_STEPS_RESET;
            slope_thr_reg   <= hdd_pkg::SLOPE_THR_RESET;
            settle_inc_reg  <= hdd_pkg::SETTLE_INC_RESET;
            exhaust_inc_reg <= hdd_pkg::EXHAUST_INC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hdd_pkg::CFG_MAX_STEPS:   max_steps_reg   <= cfg_data[7:0];
                hdd_pkg::CFG_SLOPE_THR:   slope_thr_reg   <= cfg_data;
                hdd_pkg::CFG_SETTLE_INC:  settle_inc_reg  <= cfg_data;
                hdd_pkg::CFG_EXHAUST_INC: exhaust_inc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // walk state
    logic [CW-1:0]    r_reg;
    logic [CW-1:0]    c_reg;
    logic [7:0]       steps_reg;
    logic [1:0]       nb_reg;
    hdd_pkg::height_t here_reg;
    logic [AW-1:0]    clr_reg;

    logic [8:0]       row_ext;
    logic [8:0]       col_ext;
    logic [8:0]       row_cl;
    logic [8:0]       col_cl;
    logic [CW-1:0]    nb_r;
    logic [CW-1:0]    nb_c;
    logic             nb_on_grid;
    logic [AW-1:0]    cur_addr;
    logic [AW-1:0]    nb_addr;
    hdd_pkg::height_t rd_data;
    logic signed [16:0] diff;
    logic signed [16:0] thr_ext;
    logic             exhausted;
    logic [9:0]       inc;
    logic signed [16:0] h_sum;
    hdd_pkg::height_t h_sat;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    hdd_pkg::height_t ram_wdata;

    // drops off the grid land on its last row or column
    assign row_ext = 9'(drop_row);
    assign col_ext = 9'(drop_col);
    assign row_cl  = (row_ext > LAST9) ? LAST9 : row_ext;
    assign col_cl  = (col_ext > LAST9) ? LAST9 : col_ext;

    always_comb
    begin
        nb_r       = r_reg;
        nb_c       = c_reg;
        nb_on_grid = 1'b0;
        unique case (nb_reg)
            NB_ROW_UP:
            begin
                nb_r       = r_reg + CW'(1);
                nb_on_grid = (r_reg != LAST);
            end
            NB_ROW_DOWN:
            begin
                nb_r       = r_reg - CW'(1);
                nb_on_grid = (r_reg != '0);
            end
            NB_COL_UP:
            begin
                nb_c       = c_reg + CW'(1);
                nb_on_grid = (c_reg != LAST);
            end
            NB_COL_DOWN:
            begin
                nb_c       = c_reg - CW'(1);
                nb_on_grid = (c_reg != '0);
            end
            default: ;
        endcase
    end

    assign cur_addr = AW'(r_reg) * GRID_A + AW'(c_reg);
    assign nb_addr  = AW'(nb_r) * GRID_A + AW'(nb_c);

    // slope test at 17 bits, no overflow
    assign diff    = 17'(here_reg) - 17'(rd_data);
    assign thr_ext = signed'({7'd0, slope_thr_reg});

    // walk only stops on the budget when moves made reach max_steps
    assign exhausted = (steps_reg == max_steps_reg);
    assign inc       = exhausted ? exhaust_inc_reg : settle_inc_reg;
    assign h_sum     = 17'(here_reg) + signed'({7'd0, inc});
    assign h_sat     = (h_sum > 17'(hdd_pkg::HEIGHT_MAX)) ? hdd_pkg::HEIGHT_MAX
                                                          : h_sum[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_drop)
        begin
            r_reg     <= row_cl[CW-1:0];
            c_reg     <= col_cl[CW-1:0];
            steps_reg <= '0;
        end
        else if (cmd.move)
        begin
            r_reg     <= nb_r;
            c_reg     <= nb_c;
            steps_reg <= steps_reg + 8'd1;
        end
        if (cmd.cap_here || cmd.move)
        begin
            here_reg <= rd_data;
        end
        if (cmd.nb_clr)
        begin
            nb_reg <= NB_ROW_UP;
        end
        else if (cmd.nb_next)
        begin
            nb_reg <= nb_reg + 2'd1;
        end
    end

    assign ram_we    = cmd.clear_step || cmd.update;
    assign ram_waddr = cmd.clear_step ? clr_reg : cur_addr;
    assign ram_wdata = cmd.clear_step ? hdd_pkg::HEIGHT_RESET : h_sat;

    hdd_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd.rd_nb ? nb_addr : cur_addr),
        .rdata (rd_data)
    );

    assign sts.clear_done  = (clr_reg == CLR_LAST);
    assign sts.budget_done = exhausted;
    assign sts.nb_on_grid  = nb_on_grid;
    assign sts.nb_lower    = (diff > thr_ext);
    assign sts.nb_last     = (nb_reg == NB_COL_DOWN);

    // result registers
    logic             done_reg;
    logic [8:0]       rest_r9;
    logic [8:0]       rest_c9;
    logic [5:0]       rest_row_reg;
    logic [5:0]       rest_col_reg;
    hdd_pkg::height_t new_height_reg;
    logic [7:0]       steps_out_reg;
    logic             exh_out_reg;

    assign rest_r9 = 9'(r_reg);
    assign rest_c9 = 9'(c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rest_row_reg   <= rest_r9[5:0];
            rest_col_reg   <= rest_c9[5:0];
            new_height_reg <= h_sat;
            steps_out_reg  <= steps_reg;
            exh_out_reg    <= exhausted;
        end
    end

    assign done             = done_reg;
    assign rest_row         = rest_row_reg;
    assign rest_col         = rest_col_reg;
    assign new_height       = new_height_reg;
    assign steps_taken      = steps_out_reg;
    assign budget_exhausted = exh_out_reg;

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (steps_taken <= max_steps_reg))
        else $error("more moves than the budget allows");

    a_exhausted_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && budget_exhausted) |-> (steps_taken == max_steps_reg))
        else $error("budget flag without a spent budget");

    a_height_rises: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (new_height >= $past(here_reg)))
        else $error("deposited height below the old height");

endmodule
`default_nettype wire

// File: rtl/core/heightmap_downhill_deposit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_downhill_deposit
// drops material on a square height map, walks it downhill and deposits
// the settle or exhausted increment where the walk ends
// ----------------------------------------------------------------------------
//
//  channel   signals                                   accepted when
//  -------   ----------------------------------------  -------------------------
//  drop      start, busy, drop_row, drop_col           start && !busy
//  result    done, rest_row, rest_col, new_height,     done (one cycle, no stall)
//            steps_taken, budget_exhausted
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// walk: busy stays high from the read of the drop cell through the neighbour
//   scans to the map write; a scan reads the neighbours on the grid one by one
//   and skips those off it, and no last scan is made when the budget ran out;
//   the single read port of the height map sets this pace; the result strobe
//   shows in the first idle cycle, the cycle after the map write
// reset: a clearing pass writes -650 to all GRID*GRID cells, one per cycle,
//   with busy held high; config is taken as ever
// stalls: the receiver cannot stall; a new drop is taken in the cycle the
//   result strobe is shown
//
module heightmap_downhill_deposit #(
    parameter int GRID = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // drop items
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [5:0]                     drop_row,
    input  wire logic [5:0]                     drop_col,

    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hdd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hdd_pkg::CFG_DATA_W-1:0] cfg_data,

    // result items
    output logic                                done,
    output logic [5:0]                          rest_row,
    output logic [5:0]                          rest_col,
    output hdd_pkg::height_t                    new_height,
    output logic [7:0]                          steps_taken,
    output logic                                budget_exhausted
);

    hdd_pkg::hdd_cmd_t cmd;
    hdd_pkg::hdd_sts_t sts;
    logic              ctrl_busy;

    // config writes go straight into the registers, so the port is always ready
    assign cfg_ready = 1'b1;

    // sequencer: clear pass, walk steps, update
    hdd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (ctrl_busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // height map, position, neighbour test and result registers
    hdd_datapath #(
        .GRID (GRID)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .drop_row         (drop_row),
        .drop_col         (drop_col),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .rest_row         (rest_row),
        .rest_col         (rest_col),
        .new_height       (new_height),
        .steps_taken      (steps_taken),
        .budget_exhausted (budget_exhausted)
    );

    assign busy = ctrl_busy;

endmodule
`default_nettype wire
